FILE: rtl/sha256_byte_stream_hasher_top_macros.svh
// Assertion macros shared by the SHA-256 hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shb assertion failed");

// Next-cycle implication, disabled during reset.
`define SHB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shb assertion failed");

// A condition that must never be seen.
`define SHB_ASSERT_NEVER(lbl, clk, rst, expr) \
  `SHB_ASSERT_IMPL(lbl, clk, rst, 1'b1, !(expr))

`endif

FILE: rtl/shb_pkg.sv
// Shared types, constants and round-constant table of the SHA-256 hasher.
`default_nettype none
package shb_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_START,
    S_WAIT,
    S_OUT
  } shb_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD
  } shb_cmp_state_t;

  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       start;
    logic       reinit;
  } shb_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [1:0] LAST_IDX = 2'd3;

  // Element 0 is the first chaining word (a).
  localparam logic [7:0][31:0] INIT_WORDS = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/shb_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
`default_nettype none
interface shb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface shb_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: rtl/shb_compress.sv
// SHA-256 round unit: block shift line, message schedule and chaining words.
`default_nettype none
module shb_compress (
  input  logic             clk,
  input  logic             rst,
  input  shb_pkg::shb_cmd_t cmd,
  output logic             done,
  output logic [255:0]     digest
);
  import shb_pkg::*;

  shb_cmp_state_t    cst;
  shb_cmp_state_t    cst_next;
  logic [5:0]        rnd;
  logic [7:0][31:0]  h;
  logic [7:0][31:0]  v;
  logic [511:0]      blk;
  logic [31:0]       w0;
  logic [31:0]       w1;
  logic [31:0]       w9;
  logic [31:0]       w14;
  logic [31:0]       w_new;
  logic [31:0]       big0;
  logic [31:0]       big1;
  logic [31:0]       choose;
  logic [31:0]       major;
  logic [31:0]       tsum1;
  logic [31:0]       tsum2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // The oldest schedule word sits at the top of the shift line.
  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];

  always_comb begin
    w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
          + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;
    big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    tsum1  = v[7] + big1 + choose + round_const(rnd) + w0;
    tsum2  = big0 + major;
  end

  always_comb begin
    cst_next = cst;
    unique case (cst)
      C_IDLE:  if (cmd.start) cst_next = C_ROUND;
      C_ROUND: if (rnd == LAST_POS) cst_next = C_ADD;
      C_ADD:   cst_next = C_IDLE;
      default: cst_next = C_IDLE;
    endcase
  end

  always_comb begin
    done = 1'b0;
    unique case (cst)
      C_ADD:   done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_IDLE;
      rnd <= '0;
    end else begin
      cst <= cst_next;
      if (cst == C_ROUND) rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_en) begin
      blk <= {blk[503:0], cmd.byte_val};
    end else if (cst == C_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cst == C_IDLE && cmd.start) begin
      v <= h;
    end else if (cst == C_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + tsum1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= tsum1 + tsum2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      h <= INIT_WORDS;
    end else if (cst == C_ADD) begin
      for (int i = 0; i < 8; i++) begin
        h[i] <= h[i] + v[i];
      end
    end
  end

  assign digest = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};

endmodule
`default_nettype wire

FILE: rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 hasher that takes a message one byte per transfer and returns the digest
// as four 64-bit words. A byte that does not complete a 64-byte block is taken
// without holding the input off. The byte that completes a block, and the end of a
// message, hold the input off while the shared round unit works through each block:
// a start step, 64 rounds at one round per cycle, and an add into the chaining words.
// At the end of a message the padding and length bytes are shifted in one per cycle,
// from the marker position to the end of the block, plus a whole block of 64 when the
// length field does not fit; one or two blocks are padded and hashed, after which the
// four digest words are offered, most significant first. The hasher then restarts
// with fresh chaining words and a zero length.
`default_nettype none
module sha256_byte_stream_hasher_top (
  input  logic                clk,
  input  logic                rst,
  shb_byte_if.sink            msg_in,
  shb_digest_if.source        digest_out
);
  import shb_pkg::*;

  shb_state_t     state;
  shb_state_t     state_next;
  shb_cmd_t       cmd;
  logic           cmp_done;
  logic [255:0]   digest;
  logic [63:0]    byte_count;
  logic [63:0]    cnt_next;
  logic [63:0]    len_sh;
  logic [5:0]     pad_pos;
  logic [1:0]     widx;
  logic           fin;
  logic           first;
  logic           extra;
  logic           extra_now;
  logic           last_blk;
  logic           in_acc;
  logic           out_acc;
  logic [7:0]     pad_byte;

  shb_compress u_compress (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .done   (cmp_done),
    .digest (digest)
  );

  assign in_acc   = msg_in.valid && msg_in.ready;
  assign out_acc  = digest_out.valid && digest_out.ready;
  assign cnt_next = byte_count + 64'(msg_in.byte_present);

  // The 0x80 marker at or past the length field pushes the length into a second block.
  assign extra_now = first ? (pad_pos >= LEN_POS) : extra;

  always_comb begin
    if (first) begin
      pad_byte = PAD_BYTE;
    end else if (pad_pos >= LEN_POS && !extra) begin
      pad_byte = len_sh[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (msg_in.byte_present && byte_count[5:0] == LAST_POS) begin
            state_next = S_START;
          end else if (msg_in.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD:   if (pad_pos == LAST_POS) state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT: begin
        if (cmp_done) begin
          if (last_blk) begin
            state_next = S_OUT;
          end else if (fin) begin
            state_next = S_PAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_OUT:   if (out_acc && widx == LAST_IDX) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    msg_in.ready     = 1'b0;
    digest_out.valid = 1'b0;
    cmd              = '0;
    unique case (state)
      S_IDLE: begin
        msg_in.ready = 1'b1;
        cmd.byte_en  = in_acc && msg_in.byte_present;
        cmd.byte_val = msg_in.data_byte;
      end
      S_PAD: begin
        cmd.byte_en  = 1'b1;
        cmd.byte_val = pad_byte;
      end
      S_START: cmd.start = 1'b1;
      S_WAIT:  cmd.start = 1'b0;
      S_OUT: begin
        digest_out.valid = 1'b1;
        cmd.reinit       = out_acc && widx == LAST_IDX;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      fin        <= 1'b0;
      first      <= 1'b0;
      extra      <= 1'b0;
      last_blk   <= 1'b0;
      widx       <= '0;
      pad_pos    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            byte_count <= cnt_next;
            if (msg_in.end_of_message) begin
              fin      <= 1'b1;
              first    <= 1'b1;
              extra    <= 1'b0;
              last_blk <= 1'b0;
              pad_pos  <= cnt_next[5:0];
            end
          end
        end
        S_PAD: begin
          first   <= 1'b0;
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == LAST_POS) begin
            last_blk <= !extra_now;
            extra    <= 1'b0;
          end else begin
            extra <= extra_now;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            widx <= widx + 2'd1;
            if (widx == LAST_IDX) begin
              byte_count <= '0;
              fin        <= 1'b0;
              last_blk   <= 1'b0;
            end
          end
        end
        default: widx <= widx;
      endcase
    end
  end

  // The bit length shifts out from its top byte while the length field is filled.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc && msg_in.end_of_message) begin
      len_sh <= {cnt_next[60:0], 3'b000};
    end else if (state == S_PAD && !first && pad_pos >= LEN_POS && !extra) begin
      len_sh <= {len_sh[55:0], 8'h00};
    end
  end

  always_comb begin
    case (widx)
      2'd0:    digest_out.digest_word = digest[255:192];
      2'd1:    digest_out.digest_word = digest[191:128];
      2'd2:    digest_out.digest_word = digest[127:64];
      default: digest_out.digest_word = digest[63:0];
    endcase
  end

  assign digest_out.word_index = widx;
  assign digest_out.last_word  = (widx == LAST_IDX);

endmodule
`default_nettype wire

FILE: rtl/shb_checker.sv
// Port-level checker for the SHA-256 hasher and its bind to the top level.
`default_nettype none
`include "sha256_byte_stream_hasher_top_macros.svh"
module shb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] word_index,
  input logic       last_word
);

  // The hasher never takes a byte while a digest word is on offer.
  `SHB_ASSERT_NEVER(a_no_overlap, clk, rst, out_valid && in_ready)

  `SHB_ASSERT_IMPL(a_last_flag, clk, rst, out_valid, last_word == (word_index == 2'd3))

  `SHB_ASSERT_NEXT(a_word_order, clk, rst, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 2'd1)

  // After the last digest word the hasher is ready for a new message at once.
  `SHB_ASSERT_NEXT(a_restart, clk, rst, out_valid && out_ready && last_word, !out_valid && in_ready)

endmodule

bind sha256_byte_stream_hasher_top shb_checker u_shb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (msg_in.valid),
  .in_ready   (msg_in.ready),
  .out_valid  (digest_out.valid),
  .out_ready  (digest_out.ready),
  .word_index (digest_out.word_index),
  .last_word  (digest_out.last_word)
);
`default_nettype wire
